// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// expression must never hold
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

// ===== rtl/lbs_pkg.sv =====
// types and constants of the list builder store
`timescale 1ns / 1ps
package lbs_pkg;

  localparam logic [2:0] OPC_APPEND = 3'd0;
  localparam logic [2:0] OPC_GET    = 3'd1;
  localparam logic [2:0] OPC_NEXT   = 3'd2;
  localparam logic [2:0] OPC_DELETE = 3'd3;
  localparam logic [2:0] OPC_DROP   = 3'd4;
  localparam logic [2:0] OPC_DUMP   = 3'd5;
  localparam logic [2:0] OPC_CLEAR  = 3'd6;

  localparam logic [1:0] CH_LIST    = 2'd0;
  localparam logic [1:0] CH_DELETED = 2'd1;
  localparam logic [1:0] CH_EMPTY   = 2'd2;
  localparam logic [1:0] CH_REJECT  = 2'd3;

  localparam logic [1:0] TAG_INT    = 2'd0;
  localparam logic [1:0] TAG_FLOAT  = 2'd1;
  localparam logic [1:0] TAG_SYMBOL = 2'd2;
  localparam logic [1:0] TAG_UNUSED = 2'd3;

  localparam int unsigned ENTRY_W = 34;

  typedef enum logic [2:0] {
    K_APPEND,
    K_GET,
    K_NEXT,
    K_DELETE,
    K_DROP,
    K_DUMP,
    K_CLEAR
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [1:0]  tag;
    logic [31:0] word;
    logic        dump_after;
    logic [7:0]  start;
    logic [7:0]  count;
  } cmd_t;

endpackage

// ===== rtl/list_builder_store.sv =====
// top level of the list builder store
// a command leaving the queue moves the fsm to the run state, whose registered read data and
// valid give the first list word, then one word per cycle; an empty or reject signal is registered
// get, next and dump emit a run; delete and drop emit the deleted words, then close the gap
// by moving later words down; a new command is taken only when the back end is idle again
// a two command queue accepts commands during a run; busy rises once both entries are full
// reset: asynchronous, leaves an empty list with read position zero; results cannot stall
`timescale 1ns / 1ps
`include "assert_macros.svh"
module list_builder_store import lbs_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  opcode_i,
  input  logic [1:0]  value_tag_i,
  input  logic [31:0] value_word_i,
  input  logic        dump_after_i,
  input  logic [7:0]  start_index_i,
  input  logic [7:0]  run_count_i,
  output logic        result_valid_o,
  output logic [1:0]  channel_o,
  output logic [1:0]  out_tag_o,
  output logic [31:0] out_word_o,
  output logic        last_o
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  lbs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .opcode_i      (opcode_i),
    .value_tag_i   (value_tag_i),
    .value_word_i  (value_word_i),
    .dump_after_i  (dump_after_i),
    .start_index_i (start_index_i),
    .run_count_i   (run_count_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  lbs_back #(.DEPTH(DEPTH)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .result_valid_o (result_valid_o),
    .channel_o      (channel_o),
    .out_tag_o      (out_tag_o),
    .out_word_o     (out_word_o),
    .last_o         (last_o)
  );

  `ASSERT_IMPLY(a_signal_zero, clk_i, rst_ni, result_valid_o && (channel_o == CH_EMPTY || channel_o == CH_REJECT), out_word_o == 32'd0 && out_tag_o == 2'd0)
  `ASSERT_IMPLY(a_signal_last, clk_i, rst_ni, result_valid_o && (channel_o == CH_EMPTY || channel_o == CH_REJECT), last_o)
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, cmd_pop && !cmd_valid)

endmodule

// ===== rtl/lbs_ram.sv =====
// generic single write, single read ram with registered read
`timescale 1ns / 1ps
module lbs_ram #(
  parameter int unsigned WIDTH = 34,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lbs_front.sv =====
// command intake, decode and two entry command queue
`timescale 1ns / 1ps
module lbs_front import lbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  opcode_i,
  input  logic [1:0]  value_tag_i,
  input  logic [31:0] value_word_i,
  input  logic        dump_after_i,
  input  logic [7:0]  start_index_i,
  input  logic [7:0]  run_count_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_pop_i
);

  cmd_t       slot_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] fill_q, fill_d;
  logic       push, known;
  cmd_t       dec;

  always_comb begin
    known = 1'b1;
    dec.kind = K_APPEND;
    unique case (opcode_i)
      OPC_APPEND: dec.kind = K_APPEND;
      OPC_GET:    dec.kind = K_GET;
      OPC_NEXT:   dec.kind = K_NEXT;
      OPC_DELETE: dec.kind = K_DELETE;
      OPC_DROP:   dec.kind = K_DROP;
      OPC_DUMP:   dec.kind = K_DUMP;
      OPC_CLEAR:  dec.kind = K_CLEAR;
      default:    known = 1'b0;
    endcase
    // undefined tag stored as integer
    dec.tag        = (value_tag_i == TAG_UNUSED) ? TAG_INT : value_tag_i;
    dec.word       = value_word_i;
    dec.dump_after = dump_after_i;
    dec.start      = start_index_i;
    dec.count      = run_count_i;
  end

  assign busy_o      = (fill_q == 2'd2);
  assign push        = start_i && !busy_o && known;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (push) begin
      wptr_d = ~wptr_q;
    end
    if (cmd_pop_i) begin
      rptr_d = ~rptr_q;
    end
    unique case ({push, cmd_pop_i})
      2'b10:   fill_d = fill_q + 2'd1;
      2'b01:   fill_d = fill_q - 2'd1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

endmodule

// ===== rtl/lbs_back.sv =====
// command execution: list storage, run emission and gap closing
`timescale 1ns / 1ps
module lbs_back import lbs_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  output logic        result_valid_o,
  output logic [1:0]  channel_o,
  output logic [1:0]  out_tag_o,
  output logic [31:0] out_word_o,
  output logic        last_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned LW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (LW > 8) ? LW : 8;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_SHIFT = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [LW-1:0]   len_q, len_d;
  logic [AW-1:0]   rp_q, rp_d;
  logic [AW-1:0]   here_q, here_d;
  logic [LW-1:0]   left_q, left_d;
  logic [LW-1:0]   src_q, src_d, dst_q, dst_d;
  logic            get_q, get_d, del_q, del_d;
  logic            sh_v_q, sh_v_d;
  logic            val_q, val_d, ram_q, ram_d, last_q, last_d;
  logic [1:0]      ch_q, ch_d;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;

  logic [CW-1:0]   len_w, cnt_w, idx_w, base_w, gcnt_w, dcnt_w, avail_w;
  logic [AW-1:0]   here_nx;

  lbs_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    len_w = CW'(len_q);
    cnt_w = CW'(cmd_i.count);
    idx_w = (cmd_i.kind == K_GET) ? CW'(cmd_i.start) : CW'(rp_q);
    if (cnt_w == '0) begin
      gcnt_w = CW'(1);
    end else if (cnt_w > CW'(DEPTH)) begin
      gcnt_w = CW'(DEPTH);
    end else begin
      gcnt_w = cnt_w;
    end
    if (cmd_i.kind == K_DELETE) begin
      base_w = CW'(cmd_i.start);
    end else if (cnt_w >= len_w) begin
      base_w = '0;
    end else begin
      base_w = len_w - cnt_w;
    end
    avail_w = len_w - base_w;
    dcnt_w  = (cnt_w == '0) ? CW'(1) : cnt_w;
    if (dcnt_w > avail_w) begin
      dcnt_w = avail_w;
    end
    here_nx = ((LW'(here_q) + LW'(1)) >= len_q) ? '0 : here_q + AW'(1);
  end

  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    rp_d    = rp_q;
    here_d  = here_q;
    left_d  = left_q;
    src_d   = src_q;
    dst_d   = dst_q;
    get_d   = get_q;
    del_d   = del_q;
    sh_v_d  = 1'b0;
    val_d   = 1'b0;
    ram_d   = 1'b0;
    last_d  = 1'b0;
    ch_d    = ch_q;
    cmd_pop_o = 1'b0;
    we      = 1'b0;
    waddr   = AW'(len_q);
    wdata   = {cmd_i.tag, cmd_i.word};
    raddr   = here_q;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.kind)
            K_APPEND: begin
              if (len_q >= LW'(DEPTH)) begin
                val_d  = 1'b1;
                last_d = 1'b1;
                ch_d   = CH_REJECT;
              end else begin
                we    = 1'b1;
                len_d = len_q + LW'(1);
                if (cmd_i.dump_after) begin
                  rp_d    = '0;
                  here_d  = '0;
                  left_d  = len_q + LW'(1);
                  get_d   = 1'b0;
                  del_d   = 1'b0;
                  ch_d    = CH_LIST;
                  state_d = ST_RUN;
                end
              end
            end
            K_GET, K_NEXT: begin
              if (idx_w >= len_w) begin
                val_d  = 1'b1;
                last_d = 1'b1;
                ch_d   = CH_EMPTY;
              end else begin
                here_d  = AW'(idx_w);
                left_d  = LW'(gcnt_w);
                get_d   = 1'b1;
                del_d   = 1'b0;
                ch_d    = CH_LIST;
                state_d = ST_RUN;
              end
            end
            K_DELETE, K_DROP: begin
              if (len_q != '0 && base_w < len_w) begin
                here_d  = AW'(base_w);
                left_d  = LW'(dcnt_w);
                src_d   = LW'(base_w + dcnt_w);
                dst_d   = LW'(base_w);
                rp_d    = '0;
                get_d   = 1'b0;
                del_d   = 1'b1;
                ch_d    = CH_DELETED;
                state_d = ST_RUN;
              end
            end
            K_DUMP: begin
              rp_d = '0;
              if (len_q == '0) begin
                val_d  = 1'b1;
                last_d = 1'b1;
                ch_d   = CH_EMPTY;
              end else begin
                here_d  = '0;
                left_d  = len_q;
                get_d   = 1'b0;
                del_d   = 1'b0;
                ch_d    = CH_LIST;
                state_d = ST_RUN;
              end
            end
            K_CLEAR: begin
              len_d = '0;
              rp_d  = '0;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        raddr  = here_q;
        val_d  = 1'b1;
        ram_d  = 1'b1;
        last_d = (left_q == LW'(1));
        here_d = here_nx;
        left_d = left_q - LW'(1);
        if (left_q == LW'(1)) begin
          if (get_q) begin
            rp_d = here_nx;
          end
          state_d = del_q ? ST_SHIFT : ST_IDLE;
        end
      end
      ST_SHIFT: begin
        raddr = AW'(src_q);
        waddr = AW'(dst_q);
        wdata = rdata;
        if (src_q < len_q) begin
          sh_v_d = 1'b1;
          src_d  = src_q + LW'(1);
        end
        if (sh_v_q) begin
          we    = 1'b1;
          dst_d = dst_q + LW'(1);
        end
        if (!(src_q < len_q) && !sh_v_q) begin
          len_d   = dst_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      rp_q    <= '0;
      sh_v_q  <= 1'b0;
      val_q   <= 1'b0;
      ram_q   <= 1'b0;
      last_q  <= 1'b0;
      ch_q    <= CH_LIST;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      rp_q    <= rp_d;
      sh_v_q  <= sh_v_d;
      val_q   <= val_d;
      ram_q   <= ram_d;
      last_q  <= last_d;
      ch_q    <= ch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    here_q <= here_d;
    left_q <= left_d;
    src_q  <= src_d;
    dst_q  <= dst_d;
    get_q  <= get_d;
    del_q  <= del_d;
  end

  assign result_valid_o = val_q;
  assign channel_o      = ch_q;
  assign last_o         = last_q;
  assign out_tag_o      = ram_q ? rdata[ENTRY_W-1:32] : 2'd0;
  assign out_word_o     = ram_q ? rdata[31:0] : 32'd0;

endmodule
